/* sv/dfpg_pkg.sv */
// ----------------------------------------------------------------------------
// dfpg_pkg
// Shared types, codes and the weight coding helper for the time-code frame
// pulse generator.
// ----------------------------------------------------------------------------
package dfpg_pkg;

    localparam int FRAME_BITS = 59;

    localparam logic       ACT_LOAD = 1'b0;
    localparam logic       ACT_TICK = 1'b1;

    localparam logic [1:0] SYM_ZERO = 2'd0;
    localparam logic [1:0] SYM_ONE  = 2'd1;
    localparam logic [1:0] SYM_NONE = 2'd2;

    localparam logic [1:0] CFG_ZERO_PULSE = 2'd0;
    localparam logic [1:0] CFG_ONE_PULSE  = 2'd1;
    localparam logic [1:0] CFG_SECOND     = 2'd2;
    localparam logic [1:0] CFG_LEAD_BITS  = 2'd3;

    localparam logic [15:0] RST_ZERO_PULSE = 16'd100;
    localparam logic [15:0] RST_ONE_PULSE  = 16'd200;
    localparam logic [15:0] RST_SECOND     = 16'd1000;
    localparam logic [15:0] RST_LEAD_BITS  = 16'hFFFF;

    localparam logic [5:0] LAST_SECOND = 6'd59;

    typedef logic [0:7][7:0] t_wt_list;

    // leading entries of 255 are never reached by a 7-bit value
    localparam t_wt_list WT_MINUTE  = {8'd255, 8'd40, 8'd20, 8'd10, 8'd8, 8'd4, 8'd2, 8'd1};
    localparam t_wt_list WT_HOUR    = {8'd255, 8'd255, 8'd20, 8'd10, 8'd8, 8'd4, 8'd2, 8'd1};
    localparam t_wt_list WT_WEEKDAY = {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd4, 8'd2,
                                       8'd1};
    localparam t_wt_list WT_MONTH   = {8'd255, 8'd255, 8'd255, 8'd10, 8'd8, 8'd4, 8'd2, 8'd1};
    localparam t_wt_list WT_YEAR    = {8'd80, 8'd40, 8'd20, 8'd10, 8'd8, 8'd4, 8'd2, 8'd1};

    typedef struct packed {
        logic       action;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [2:0] weekday;
        logic [3:0] month;
        logic [6:0] year;
        logic       summer_time;
    } t_in_item;

    typedef struct packed {
        logic       pin_level;
        logic [5:0] second_index;
        logic [1:0] symbol;
        logic       frame_done;
    } t_out_item;

    typedef struct packed {
        logic [15:0] zero_pulse_ticks;
        logic [15:0] one_pulse_ticks;
        logic [15:0] second_ticks;
        logic [15:0] lead_bits;
    } t_cfg;

    // greedy weight coding, least significant weight lands in bit 0
    function automatic logic [7:0] bcd_greedy(input logic [6:0] value, input t_wt_list w);
        logic [7:0] rem;
        logic [7:0] bits;
        rem  = {1'b0, value};
        bits = '0;
        for (int i = 0; i < 8; i++) begin
            if (rem >= w[i]) begin
                rem = rem - w[i];
                bits[3'(7 - i)] = 1'b1;
            end
        end
        return bits;
    endfunction

endpackage

/* sv/dfpg_cfg.sv */
// ----------------------------------------------------------------------------
// dfpg_cfg
// Configuration register file: pulse lengths, slot length and lead bits.
// ----------------------------------------------------------------------------
module dfpg_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output dfpg_pkg::t_cfg    o_cfg
);

    dfpg_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_pulse_ticks <= dfpg_pkg::RST_ZERO_PULSE;
            r_cfg.one_pulse_ticks  <= dfpg_pkg::RST_ONE_PULSE;
            r_cfg.second_ticks     <= dfpg_pkg::RST_SECOND;
            r_cfg.lead_bits        <= dfpg_pkg::RST_LEAD_BITS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dfpg_pkg::CFG_ZERO_PULSE: r_cfg.zero_pulse_ticks <= i_cfg_data;
                dfpg_pkg::CFG_ONE_PULSE:  r_cfg.one_pulse_ticks  <= i_cfg_data;
                dfpg_pkg::CFG_SECOND:     r_cfg.second_ticks     <= i_cfg_data;
                dfpg_pkg::CFG_LEAD_BITS:  r_cfg.lead_bits        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

/* sv/dfpg_frame.sv */
// ----------------------------------------------------------------------------
// dfpg_frame
// Build the 59-bit minute frame from a load transaction and the lead bits.
// ----------------------------------------------------------------------------
module dfpg_frame (
    input  dfpg_pkg::t_in_item                  i_item,
    input  logic [15:0]                         i_lead_bits,
    output logic [dfpg_pkg::FRAME_BITS-1:0]     o_frame
);

    logic [2:0] w_weekday;
    logic [6:0] w_min;
    logic [5:0] w_hour;
    logic [5:0] w_day;
    logic [2:0] w_wday;
    logic [4:0] w_month;
    logic [7:0] w_year;
    logic [7:0] w_min_full;
    logic [7:0] w_hour_full;
    logic [7:0] w_day_full;
    logic [7:0] w_wday_full;
    logic [7:0] w_month_full;
    logic       w_date_par;

    always_comb begin
        w_weekday    = (i_item.weekday == 3'd0) ? 3'd7 : i_item.weekday;
        w_min_full   = dfpg_pkg::bcd_greedy({1'b0, i_item.minute}, dfpg_pkg::WT_MINUTE);
        w_hour_full  = dfpg_pkg::bcd_greedy({2'b0, i_item.hour}, dfpg_pkg::WT_HOUR);
        w_day_full   = dfpg_pkg::bcd_greedy({2'b0, i_item.day}, dfpg_pkg::WT_HOUR);
        w_wday_full  = dfpg_pkg::bcd_greedy({4'b0, w_weekday}, dfpg_pkg::WT_WEEKDAY);
        w_month_full = dfpg_pkg::bcd_greedy({3'b0, i_item.month}, dfpg_pkg::WT_MONTH);
        w_year       = dfpg_pkg::bcd_greedy(i_item.year, dfpg_pkg::WT_YEAR);
        w_min        = w_min_full[6:0];
        w_hour       = w_hour_full[5:0];
        w_day        = w_day_full[5:0];
        w_wday       = w_wday_full[2:0];
        w_month      = w_month_full[4:0];
        w_date_par   = ^{w_day, w_wday, w_month, w_year};

        o_frame = {w_date_par, w_year, w_month, w_wday, w_day,
                   ^w_hour, w_hour, ^w_min, w_min,
                   1'b1, 1'b0, ~i_item.summer_time, i_item.summer_time, 1'b0,
                   i_lead_bits};
    end

endmodule

/* sv/dfpg_core.sv */
// ----------------------------------------------------------------------------
// dfpg_core
// Frame and timebase state, and the result for each transaction.
// ----------------------------------------------------------------------------
module dfpg_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  dfpg_pkg::t_in_item                  i_item,
    input  dfpg_pkg::t_cfg                      i_cfg,
    input  logic [dfpg_pkg::FRAME_BITS-1:0]     i_frame,
    output dfpg_pkg::t_out_item                 o_result
);

    logic [dfpg_pkg::FRAME_BITS-1:0] r_frame;
    logic [dfpg_pkg::FRAME_BITS-1:0] n_frame;
    logic [5:0]                      r_sec;
    logic [5:0]                      n_sec;
    logic [15:0]                     r_tick;
    logic [15:0]                     n_tick;
    logic                            r_loaded;
    logic                            n_loaded;

    logic [63:0] w_frame_ext;
    logic [1:0]  w_sym;
    logic [15:0] w_len;
    logic        w_last;

    always_comb begin
        w_frame_ext = {{(64 - dfpg_pkg::FRAME_BITS){1'b0}}, r_frame};
        w_sym  = (r_sec >= dfpg_pkg::LAST_SECOND) ? dfpg_pkg::SYM_NONE
                                                  : {1'b0, w_frame_ext[r_sec]};
        case (w_sym)
            dfpg_pkg::SYM_ZERO: w_len = i_cfg.zero_pulse_ticks;
            dfpg_pkg::SYM_ONE:  w_len = i_cfg.one_pulse_ticks;
            default:            w_len = 16'd0;
        endcase
        w_last = ({1'b0, r_tick} + 17'd1) >= {1'b0, i_cfg.second_ticks};

        n_frame  = r_frame;
        n_sec    = r_sec;
        n_tick   = r_tick;
        n_loaded = r_loaded;
        o_result = '{pin_level: 1'b0, second_index: 6'd0, symbol: dfpg_pkg::SYM_NONE,
                     frame_done: 1'b0};

        if (i_item.action == dfpg_pkg::ACT_LOAD) begin
            n_frame  = i_frame;
            n_sec    = 6'd0;
            n_tick   = 16'd0;
            n_loaded = 1'b1;
            o_result.symbol = {1'b0, i_frame[0]};
        end else if (r_loaded) begin
            o_result.pin_level    = r_tick < w_len;
            o_result.second_index = r_sec;
            o_result.symbol       = w_sym;
            o_result.frame_done   = w_last && (r_sec == dfpg_pkg::LAST_SECOND);
            if (w_last) begin
                n_tick = 16'd0;
                n_sec  = (r_sec >= dfpg_pkg::LAST_SECOND) ? 6'd0 : r_sec + 6'd1;
            end else begin
                n_tick = r_tick + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame  <= '0;
            r_sec    <= 6'd0;
            r_tick   <= 16'd0;
            r_loaded <= 1'b0;
        end else if (i_en) begin
            r_frame  <= n_frame;
            r_sec    <= n_sec;
            r_tick   <= n_tick;
            r_loaded <= n_loaded;
        end
    end

`ifndef SYNTHESIS
    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec <= dfpg_pkg::LAST_SECOND)
        else $error("second position beyond last slot");

    a_idle_before_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_loaded |-> (r_sec == 6'd0) && (r_tick == 16'd0))
        else $error("timebase moved before a frame was loaded");

    a_load_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && (i_item.action == dfpg_pkg::ACT_LOAD)
        |=> r_loaded && (r_sec == 6'd0) && (r_tick == 16'd0))
        else $error("load did not restart the frame");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && (i_item.action == dfpg_pkg::ACT_TICK) && o_result.frame_done
        |=> (r_sec == 6'd0) && (r_tick == 16'd0))
        else $error("frame did not wrap after last slot");
`endif

endmodule

/* sv/dcf77_frame_pulse_generator.sv */
// ----------------------------------------------------------------------------
// dcf77_frame_pulse_generator
// Minute time-code frame builder and pulse timebase.
//
// Input channel (i_in_valid / o_in_stall, payload i_in): a transaction with
// action load latches date and time, builds the 59-bit frame and restarts at
// second 0; action tick advances the timebase by one tick.
// Output channel (o_out_valid / i_out_stall, payload o_out): one result per
// input transaction, in order, giving the pin level, slot, symbol and the
// end-of-frame flag.
// Configuration channel (i_cfg_valid / o_cfg_ready): always ready, index
// selects zero pulse, one pulse, slot length or lead bits.
// Throughput is one transaction per cycle while the receiver does not stall;
// each transaction passes the input register, then the result register, with
// the state updated as it moves from one to the other.
// When the receiver stalls, the result register holds and the input
// register keeps one further transaction before o_in_stall rises.
// Reset clears the frame, the timebase and both pipeline stages, holds the
// input stalled and loads the register defaults; ticks before the first load
// give a low pin.
// ----------------------------------------------------------------------------
module dcf77_frame_pulse_generator (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  dfpg_pkg::t_in_item      i_in,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output dfpg_pkg::t_out_item     o_out,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [15:0]             i_cfg_data
);

    dfpg_pkg::t_cfg                  w_cfg;
    logic [dfpg_pkg::FRAME_BITS-1:0] w_frame;
    dfpg_pkg::t_out_item             w_result;
    logic                            w_advance;

    logic                r_in_valid;
    dfpg_pkg::t_in_item  r_in;
    logic                r_out_valid;
    dfpg_pkg::t_out_item r_out;

    assign w_advance   = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !i_rst_n || (r_in_valid && !w_advance);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    dfpg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    dfpg_frame u_frame (
        .i_item      (r_in),
        .i_lead_bits (w_cfg.lead_bits),
        .o_frame     (w_frame)
    );

    dfpg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (r_in_valid && w_advance),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .i_frame  (w_frame),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_out <= w_result;
        end
    end

endmodule

/* tb/dcf77_frame_pulse_generator_test.sv */
// ----------------------------------------------------------------------------
// dcf77_frame_pulse_generator_test
// Self-checking bench for the minute time-code frame pulse generator. Loads
// and timebase ticks go in through the valid/stall input channel while both
// sides pause at random. A bench-side timecode model builds each frame and
// predicts the pin level, slot, symbol and end-of-frame flag of every
// transaction; results are checked in order. Phases cover ticks before any
// load, extreme and out-of-range dates, short and long slots, pulses that fill
// the slot, a slot length shrunk mid-slot, a long receiver hold-off and
// random register settings.
// ----------------------------------------------------------------------------
module dcf77_frame_pulse_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dfpg_pkg::*;

    localparam int IDLE_PERCENT    = 28;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_GAP         = 12;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in        = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_ZERO_PULSE;
    logic [15:0] i_cfg_data  = '0;

    logic [FRAME_BITS-1:0] tc_frame;
    logic [5:0]            tc_second;
    logic [15:0]           tc_tick;
    logic                  tc_loaded;
    logic [15:0]           zero_len;
    logic [15:0]           one_len;
    logic [15:0]           slot_len;
    logic [15:0]           lead_pattern;

    t_out_item pending_pulses[$];
    int        mismatch_count    = 0;
    bit        sender_idles      = 1'b1;
    bit        receiver_idles    = 1'b1;
    int        hold_off_requests = 0;
    int        hold_off_taken    = 0;
    int        hold_off_left     = 0;

    dcf77_frame_pulse_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    // greedy digit weights: tens 80/40/20/10 in bits 7..4, units 8/4/2/1 in bits 3..0
    function automatic logic [7:0] weighted_digits(input int unsigned value,
                                                   input int unsigned top_tens);
        int unsigned rest;
        int unsigned wgt;
        logic [7:0]  bits;
        rest = value;
        bits = '0;
        for (int k = 3; k >= 0; k--) begin
            wgt = 10 << k;
            if (wgt <= top_tens && rest >= wgt) begin
                rest    = rest - wgt;
                bits[4 + k] = 1'b1;
            end
        end
        for (int k = 3; k >= 0; k--) begin
            wgt = 1 << k;
            if (rest >= wgt) begin
                rest    = rest - wgt;
                bits[k] = 1'b1;
            end
        end
        return bits;
    endfunction

    function automatic void build_frame(input t_in_item it);
        logic [7:0] mins;
        logic [7:0] hrs;
        logic [7:0] days;
        logic [7:0] wday;
        logic [7:0] mon;
        logic [7:0] yrs;
        mins = weighted_digits(it.minute, 40);
        hrs  = weighted_digits(it.hour, 20);
        days = weighted_digits(it.day, 20);
        wday = weighted_digits((it.weekday == 3'd0) ? 7 : it.weekday, 0);
        mon  = weighted_digits(it.month, 10);
        yrs  = weighted_digits(it.year, 80);
        tc_frame        = '0;
        tc_frame[15:0]  = lead_pattern;
        tc_frame[17]    = it.summer_time;
        tc_frame[18]    = ~it.summer_time;
        tc_frame[20]    = 1'b1;
        tc_frame[27:21] = mins[6:0];
        tc_frame[28]    = ^mins[6:0];
        tc_frame[34:29] = hrs[5:0];
        tc_frame[35]    = ^hrs[5:0];
        tc_frame[41:36] = days[5:0];
        tc_frame[44:42] = wday[2:0];
        tc_frame[49:45] = mon[4:0];
        tc_frame[57:50] = yrs;
        tc_frame[58]    = ^tc_frame[57:36];
    endfunction

    function automatic t_out_item next_timecode_output(input t_in_item it);
        t_out_item   res;
        logic [1:0]  sym;
        logic [15:0] len;
        bit          last;
        res = '0;
        if (it.action == ACT_LOAD) begin
            build_frame(it);
            tc_second  = '0;
            tc_tick    = '0;
            tc_loaded  = 1'b1;
            res.symbol = tc_frame[0] ? SYM_ONE : SYM_ZERO;
        end else if (!tc_loaded) begin
            res.symbol = SYM_NONE;
        end else begin
            if (tc_second >= LAST_SECOND)
                sym = SYM_NONE;
            else
                sym = tc_frame[tc_second] ? SYM_ONE : SYM_ZERO;
            len = (sym == SYM_ONE) ? one_len : ((sym == SYM_ZERO) ? zero_len : 16'd0);
            last = (int'(tc_tick) + 1 >= int'(slot_len));
            res.pin_level    = (tc_tick < len);
            res.second_index = tc_second;
            res.symbol       = sym;
            res.frame_done   = last && (tc_second == LAST_SECOND);
            if (last) begin
                tc_tick   = '0;
                tc_second = (tc_second >= LAST_SECOND) ? 6'd0 : tc_second + 6'd1;
            end else begin
                tc_tick = tc_tick + 16'd1;
            end
        end
        return res;
    endfunction

    task automatic note_mismatch(input string what, input t_out_item want,
                                 input t_out_item got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%0s) at %0t: expected pin %0b slot %0d sym %0d done %0b,",
                     what, $time, want.pin_level, want.second_index, want.symbol,
                     want.frame_done,
                     " got pin %0b slot %0d sym %0d done %0b",
                     got.pin_level, got.second_index, got.symbol, got.frame_done);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pulses.size() == 0) begin
                note_mismatch("no transaction pending", '0, o_out);
            end else begin
                want = pending_pulses.pop_front();
                if (o_out.pin_level !== want.pin_level
                        || o_out.second_index !== want.second_index
                        || o_out.symbol !== want.symbol
                        || o_out.frame_done !== want.frame_done)
                    note_mismatch("field", want, o_out);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off_taken != hold_off_requests) begin
            hold_off_taken = hold_off_requests;
            hold_off_left  = HOLD_OFF_CYCLES;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_out_stall <= 1'b1;
        end else if (receiver_idles) begin
            i_out_stall <= ($urandom_range(99) < IDLE_PERCENT);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic offer_item(input t_in_item it);
        int gap;
        gap = 0;
        if (sender_idles)
            while (gap < MAX_GAP && $urandom_range(99) < IDLE_PERCENT)
                gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_pulses.push_back(next_timecode_output(it));
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_pulses.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        i_cfg_index <= index;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_ZERO_PULSE: zero_len     = value;
            CFG_ONE_PULSE:  one_len      = value;
            CFG_SECOND:     slot_len     = value;
            CFG_LEAD_BITS:  lead_pattern = value;
            default:        ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_timebase(input logic [15:0] zero_ticks, one_ticks, slot_ticks,
                                lead);
        wait_results_drained();
        write_register(CFG_ZERO_PULSE, zero_ticks);
        write_register(CFG_ONE_PULSE, one_ticks);
        write_register(CFG_SECOND, slot_ticks);
        write_register(CFG_LEAD_BITS, lead);
    endtask

    function automatic t_in_item tick_item();
        t_in_item it;
        it        = t_in_item'($urandom);
        it.action = ACT_TICK;
        return it;
    endfunction

    function automatic t_in_item date_item(input int mi, hr, dy, wd, mo, yr,
                                           input bit summer);
        t_in_item it;
        it.action      = ACT_LOAD;
        it.minute      = 6'(mi);
        it.hour        = 5'(hr);
        it.day         = 5'(dy);
        it.weekday     = 3'(wd);
        it.month       = 4'(mo);
        it.year        = 7'(yr);
        it.summer_time = summer;
        return it;
    endfunction

    function automatic t_in_item random_date();
        t_in_item it;
        it        = t_in_item'($urandom);
        it.action = ACT_LOAD;
        case ($urandom_range(11))
            0: it = date_item(0, 0, 1, 1, 1, 0, 1'b0);
            1: it = date_item(59, 23, 31, 7, 12, 99, 1'b1);
            2: it = date_item(63, 31, 31, 7, 15, 127, 1'b1);
            3: it = date_item(0, 0, 0, 0, 0, 0, 1'b0);
            4: ;
            default: begin
                it.minute  = 6'($urandom_range(59));
                it.hour    = 5'($urandom_range(23));
                it.day     = 5'($urandom_range(31, 1));
                it.weekday = 3'($urandom_range(7));
                it.month   = 4'($urandom_range(12, 1));
                it.year    = 7'($urandom_range(99));
            end
        endcase
        return it;
    endfunction

    // load a date, then tick through frames; the odd reload cuts a frame short
    task automatic run_frames(input int count);
        for (int n = 0; n < count; n++) begin
            if (n == 0 || $urandom_range(149) == 0)
                offer_item(random_date());
            else
                offer_item(tick_item());
        end
    endtask

    function automatic logic [15:0] random_pulse();
        if ($urandom_range(4) == 0)
            return 16'hFFFF;
        return 16'($urandom_range(8, 1));
    endfunction

    task automatic test_ticks_before_load();
        repeat (3) offer_item(tick_item());
    endtask

    task automatic test_load_symbols();
        offer_item(date_item(0, 0, 0, 0, 0, 0, 1'b0));
        offer_item(tick_item());
        offer_item(date_item(59, 23, 31, 7, 12, 99, 1'b1));
        offer_item(tick_item());
        offer_item(tick_item());
        offer_item(date_item(63, 31, 31, 7, 15, 127, 1'b1));
        offer_item(tick_item());
        wait_results_drained();
        write_register(CFG_LEAD_BITS, 16'h0000);
        offer_item(date_item(0, 0, 1, 0, 1, 0, 1'b0));
        offer_item(tick_item());
        offer_item(date_item(30, 12, 15, 3, 6, 50, 1'b1));
        offer_item(tick_item());
    endtask

    task automatic test_short_slots();
        set_timebase(16'd1, 16'd2, 16'd2, 16'($urandom));
        run_frames(250);
        sender_idles   = 1'b0;
        receiver_idles <= 1'b0;
        run_frames(250);
        sender_idles   = 1'b1;
        receiver_idles <= 1'b1;
    endtask

    task automatic test_full_slot_pulses();
        set_timebase(16'hFFFF, 16'd1, 16'd3, 16'h0000);
        run_frames(150);
        hold_off_requests <= hold_off_requests + 1;
        run_frames(250);
    endtask

    task automatic test_slot_shrink();
        set_timebase(16'd7, 16'd40, 16'hFFFF, 16'hFFFF);
        run_frames(60);
        wait_results_drained();
        write_register(CFG_SECOND, 16'd5);
        run_frames(100);
        wait_results_drained();
        write_register(CFG_SECOND, 16'd2);
        run_frames(100);
    endtask

    task automatic test_random_settings();
        for (int round = 0; round < 4; round++) begin
            set_timebase(random_pulse(), random_pulse(), 16'($urandom_range(6, 2)),
                         16'($urandom));
            run_frames(40);
            wait_results_drained();
            run_frames(40);
        end
    endtask

    initial begin
        tc_frame     = '0;
        tc_second    = '0;
        tc_tick      = '0;
        tc_loaded    = 1'b0;
        zero_len     = RST_ZERO_PULSE;
        one_len      = RST_ONE_PULSE;
        slot_len     = RST_SECOND;
        lead_pattern = RST_LEAD_BITS;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_ticks_before_load();
        test_load_symbols();
        test_short_slots();
        test_full_slot_pulses();
        test_slot_shrink();
        test_random_settings();
        wait_results_drained();
        repeat (4) @(negedge i_clk);
        mismatch_count += pending_pulses.size();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
sv/dfpg_pkg.sv
sv/dfpg_cfg.sv
sv/dfpg_frame.sv
sv/dfpg_core.sv
sv/dcf77_frame_pulse_generator.sv
tb/dcf77_frame_pulse_generator_test.sv
